// ===== rtl/gzip_header_skipper_defines.svh =====
// Assertion macros used by the gzip header skipper parser.
`ifndef GZIP_HEADER_SKIPPER_DEFINES_SVH
`define GZIP_HEADER_SKIPPER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define GHS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gzip header skipper: check failed");

// Next-cycle implication, checked only out of reset.
`define GHS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gzip header skipper: check failed");

`endif

// ===== rtl/ghs_pkg.sv =====
package ghs_pkg;

    // Width of the header byte counter.
    localparam int OFFSET_BITS = 24;
    localparam int HLEN_BITS   = 24;
    localparam int SKIP_BITS   = 16;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // Header constants.
    localparam logic [7:0] MAGIC1_BYTE   = 8'h1f;
    localparam logic [7:0] MAGIC2_BYTE   = 8'h8b;
    localparam logic [7:0] METHOD_DEFL   = 8'd8;
    localparam logic [7:0] FLG_RESERVED  = 8'he0;
    localparam logic [SKIP_BITS-1:0] FIXED_SKIP = SKIP_BITS'(6);
    localparam logic [SKIP_BITS-1:0] HCRC_SKIP  = SKIP_BITS'(2);

    // Stored flag bits.
    localparam int FL_HCRC    = 0;
    localparam int FL_EXTRA   = 1;
    localparam int FL_NAME    = 2;
    localparam int FL_COMMENT = 3;

    // Section levels passed to next_section.
    localparam logic [1:0] LVL_FIXED   = 2'd0;
    localparam logic [1:0] LVL_EXTRA   = 2'd1;
    localparam logic [1:0] LVL_NAME    = 2'd2;
    localparam logic [1:0] LVL_COMMENT = 2'd3;

    // Byte status codes.
    localparam logic [2:0] ST_HEADER  = 3'd0;
    localparam logic [2:0] ST_PAYLOAD = 3'd1;
    localparam logic [2:0] ST_RAW     = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_NODATA  = 3'd4;

    typedef enum logic [14:0] {
        PH_MAGIC1  = 15'b000000000000001,
        PH_MAGIC2  = 15'b000000000000010,
        PH_METHOD  = 15'b000000000000100,
        PH_FLAGS   = 15'b000000000001000,
        PH_FIXED   = 15'b000000000010000,
        PH_XLEN_LO = 15'b000000000100000,
        PH_XLEN_HI = 15'b000000001000000,
        PH_EXTRA   = 15'b000000010000000,
        PH_NAME    = 15'b000000100000000,
        PH_COMMENT = 15'b000001000000000,
        PH_HCRC    = 15'b000010000000000,
        PH_PAYLOAD = 15'b000100000000000,
        PH_RAW     = 15'b001000000000000,
        PH_BAD     = 15'b010000000000000,
        PH_NODATA  = 15'b100000000000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           byte_status;
        logic [HLEN_BITS-1:0] header_length;
    } out_item_t;

    // Section that follows the one at the given level.
    function automatic phase_t next_section(input logic [1:0] level, input logic [3:0] flags);
        phase_t ph;
        if (level < LVL_EXTRA && flags[FL_EXTRA]) begin
            ph = PH_XLEN_LO;
        end else if (level < LVL_NAME && flags[FL_NAME]) begin
            ph = PH_NAME;
        end else if (level < LVL_COMMENT && flags[FL_COMMENT]) begin
            ph = PH_COMMENT;
        end else if (flags[FL_HCRC]) begin
            ph = PH_HCRC;
        end else begin
            ph = PH_PAYLOAD;
        end
        return ph;
    endfunction

endpackage

// ===== rtl/ghs_in_stage.sv =====
module ghs_in_stage
    import ghs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register takes a new request when empty or when its item moves on.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/ghs_parser.sv =====
`include "gzip_header_skipper_defines.svh"

module ghs_parser
    import ghs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  in_item_t  item,
    output out_item_t result
);

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [3:0]             flags_reg, flags_next;
    logic [SKIP_BITS-1:0]   skip_reg, skip_next;

    phase_t                 phase_c;
    logic [OFFSET_BITS-1:0] offset_c;
    logic [3:0]             flags_c;
    logic [SKIP_BITS-1:0]   skip_c;
    phase_t                 ph;
    logic [SKIP_BITS-1:0]   skip_dec;
    logic [2:0]             status;
    logic [OFFSET_BITS-1:0] hlen;
    logic [7:0]             b;
    logic                   last;

    assign b    = item.data_byte;
    assign last = item.last_byte;

    // A first mark restarts the parse before the byte is looked at.
    always_comb begin
        if (item.first_byte) begin
            phase_c  = PH_MAGIC1;
            offset_c = '0;
            flags_c  = '0;
            skip_c   = '0;
        end else begin
            phase_c  = phase_reg;
            offset_c = offset_reg;
            flags_c  = flags_reg;
            skip_c   = skip_reg;
        end
    end

    assign skip_dec = skip_c - SKIP_BITS'(1);

    // One header step: next state and the label of this byte.
    always_comb begin
        phase_next  = phase_c;
        offset_next = offset_c;
        flags_next  = flags_c;
        skip_next   = skip_c;
        status      = ST_HEADER;
        hlen        = '0;
        ph          = phase_c;
        priority if (phase_c == PH_PAYLOAD) begin
            status = ST_PAYLOAD;
            hlen   = offset_c;
            if (last) begin
                phase_next  = PH_MAGIC1;
                offset_next = '0;
                flags_next  = '0;
                skip_next   = '0;
            end
        end else if (phase_c == PH_RAW) begin
            status = ST_RAW;
            if (last) begin
                phase_next  = PH_MAGIC1;
                offset_next = '0;
                flags_next  = '0;
                skip_next   = '0;
            end
        end else if (phase_c == PH_BAD) begin
            status = ST_BAD;
        end else if (phase_c == PH_NODATA) begin
            status = ST_NODATA;
        end else if (offset_c == OFFSET_MAX) begin
            phase_next = PH_BAD;
            status     = ST_BAD;
        end else begin
            offset_next = offset_c + OFFSET_BITS'(1);
            unique case (phase_c)
                PH_MAGIC1: begin
                    ph = (b != MAGIC1_BYTE || last) ? PH_RAW : PH_MAGIC2;
                end
                PH_MAGIC2: begin
                    ph = (b != MAGIC2_BYTE) ? PH_RAW : PH_METHOD;
                end
                PH_METHOD: begin
                    ph = (b != METHOD_DEFL) ? PH_BAD : PH_FLAGS;
                end
                PH_FLAGS: begin
                    if ((b & FLG_RESERVED) != 8'd0) begin
                        ph = PH_BAD;
                    end else begin
                        flags_next = b[4:1];
                        ph         = PH_FIXED;
                        skip_next  = FIXED_SKIP;
                    end
                end
                PH_FIXED: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        ph = next_section(LVL_FIXED, flags_c);
                    end
                end
                PH_XLEN_LO: begin
                    skip_next = SKIP_BITS'(b);
                    ph        = PH_XLEN_HI;
                end
                PH_XLEN_HI: begin
                    skip_next = skip_c | {b, 8'd0};
                    if ((skip_c | {b, 8'd0}) == '0) begin
                        ph = next_section(LVL_EXTRA, flags_c);
                    end else begin
                        ph = PH_EXTRA;
                    end
                end
                PH_EXTRA: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        ph = next_section(LVL_EXTRA, flags_c);
                    end
                end
                PH_NAME: begin
                    if (b == 8'd0) begin
                        ph = next_section(LVL_NAME, flags_c);
                    end
                end
                PH_COMMENT: begin
                    if (b == 8'd0) begin
                        ph = next_section(LVL_COMMENT, flags_c);
                    end
                end
                PH_HCRC: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        ph = PH_PAYLOAD;
                    end
                end
                default: begin
                    ph = PH_BAD;
                end
            endcase

            // Entering the header checksum loads its two-byte skip.
            if (ph == PH_HCRC && phase_c != PH_HCRC) begin
                skip_next = HCRC_SKIP;
            end

            phase_next = ph;
            priority if (ph == PH_RAW) begin
                offset_next = '0;
                status      = ST_RAW;
                if (last) begin
                    phase_next  = PH_MAGIC1;
                    offset_next = '0;
                    flags_next  = '0;
                    skip_next   = '0;
                end
            end else if (ph == PH_BAD) begin
                status = ST_BAD;
            end else if (last) begin
                phase_next = PH_NODATA;
                status     = ST_NODATA;
            end else begin
                status = ST_HEADER;
            end
        end
    end

    // Parse state moves only when the byte's result is taken by the output stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MAGIC1;
            offset_reg <= '0;
            flags_reg  <= '0;
            skip_reg   <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            flags_reg  <= flags_next;
            skip_reg   <= skip_next;
        end
    end

    assign result.byte_status   = status;
    assign result.header_length = HLEN_BITS'(hlen);

    `GHS_ASSERT_NOW(a_phase_onehot, aclk, aresetn, 1'b1, $onehot(phase_reg))
    `GHS_ASSERT_NOW(a_len_only_payload, aclk, aresetn,
        advance && result.byte_status != ST_PAYLOAD, result.header_length == '0)
    `GHS_ASSERT_NOW(a_payload_len_nonzero, aclk, aresetn,
        advance && result.byte_status == ST_PAYLOAD, result.header_length != '0)
    `GHS_ASSERT_NOW(a_bad_sticky, aclk, aresetn,
        advance && phase_reg == PH_BAD && !item.first_byte, result.byte_status == ST_BAD)
    `GHS_ASSERT_NEXT(a_idle_holds, aclk, aresetn, !advance, $stable(phase_reg))

endmodule

// ===== rtl/ghs_out_stage.sv =====
module ghs_out_stage
    import ghs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      item_valid,
    input  out_item_t result,
    output logic      advance,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // A result loads when the register is empty or is being drained.
    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== rtl/gzip_header_skipper.sv =====
// gzip member header skipper.
// Input channel s_valid/s_ready/s_data carries one image byte per request with
// first and last marks. Output channel m_valid/m_ready/m_data returns one label
// per byte: header, payload, raw, bad format or out of data, and on payload
// bytes the header length.
// An accepted input request reaches m_valid through the input register, then
// the parse step and the result register.
// Throughput is one byte per cycle while m_ready stays high; the parse state is a
// single register set updated in the same cycle that a result is loaded.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the first magic byte. When the receiver stalls, the result register
// holds, the input register fills and s_ready drops until m_ready returns.
// A first mark restarts the parse at any time; without one, the byte after the
// last byte of a payload or raw image starts a new image.
module gzip_header_skipper
    import ghs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      advance;
    logic      item_valid;
    in_item_t  item;
    out_item_t result;

    ghs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ghs_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    ghs_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== dv/gzip_header_skipper_tb.sv =====
`timescale 1ns / 1ps

module gzip_header_skipper_tb;
    import ghs_pkg::*;

    localparam int RANDOM_BYTES = 1450;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Percentage of cycles in which each side holds off.
    int        idle_pct = 17;
    int        error_count = 0;
    int        sent_count = 0;
    bit        restart_next = 1'b0;

    // Labels predicted for accepted requests, oldest first.
    out_item_t expected_labels[$];
    // Bytes of the image being assembled.
    in_item_t  image_bytes[$];

    // Parser state as the predictor sees it.
    phase_t                 cur_phase;
    logic [OFFSET_BITS-1:0] cur_offset;
    logic [3:0]             cur_flags;
    logic [SKIP_BITS-1:0]   cur_skip;

    gzip_header_skipper i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 40) begin
            $display("%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic void restart_parse();
        cur_phase  = PH_MAGIC1;
        cur_offset = '0;
        cur_flags  = '0;
        cur_skip   = '0;
    endfunction

    // Pick the header section that follows the given one.
    function automatic phase_t section_after(input logic [1:0] level);
        if (level < LVL_EXTRA && cur_flags[FL_EXTRA]) begin
            return PH_XLEN_LO;
        end
        if (level < LVL_NAME && cur_flags[FL_NAME]) begin
            return PH_NAME;
        end
        if (level < LVL_COMMENT && cur_flags[FL_COMMENT]) begin
            return PH_COMMENT;
        end
        if (cur_flags[FL_HCRC]) begin
            cur_skip = HCRC_SKIP;
            return PH_HCRC;
        end
        return PH_PAYLOAD;
    endfunction

    // Label one byte and advance the parser state.
    function automatic out_item_t predict_label(input in_item_t it);
        out_item_t lab;
        logic [7:0] d;
        d = it.data_byte;
        lab.byte_status   = ST_HEADER;
        lab.header_length = '0;
        if (it.first_byte) begin
            restart_parse();
        end
        case (cur_phase)
            PH_PAYLOAD: begin
                lab.byte_status   = ST_PAYLOAD;
                lab.header_length = HLEN_BITS'(cur_offset);
                if (it.last_byte) begin
                    restart_parse();
                end
            end
            PH_RAW: begin
                lab.byte_status = ST_RAW;
                if (it.last_byte) begin
                    restart_parse();
                end
            end
            PH_BAD: begin
                lab.byte_status = ST_BAD;
            end
            PH_NODATA: begin
                lab.byte_status = ST_NODATA;
            end
            default: begin
                if (cur_offset == OFFSET_MAX) begin
                    cur_phase       = PH_BAD;
                    lab.byte_status = ST_BAD;
                end else begin
                    cur_offset = cur_offset + 1'b1;
                    case (cur_phase)
                        PH_MAGIC1: begin
                            cur_phase = (d != MAGIC1_BYTE || it.last_byte) ? PH_RAW : PH_MAGIC2;
                        end
                        PH_MAGIC2: begin
                            cur_phase = (d != MAGIC2_BYTE) ? PH_RAW : PH_METHOD;
                        end
                        PH_METHOD: begin
                            cur_phase = (d != METHOD_DEFL) ? PH_BAD : PH_FLAGS;
                        end
                        PH_FLAGS: begin
                            if ((d & FLG_RESERVED) != 8'h00) begin
                                cur_phase = PH_BAD;
                            end else begin
                                cur_flags[FL_HCRC]    = d[1];
                                cur_flags[FL_EXTRA]   = d[2];
                                cur_flags[FL_NAME]    = d[3];
                                cur_flags[FL_COMMENT] = d[4];
                                cur_phase = PH_FIXED;
                                cur_skip  = FIXED_SKIP;
                            end
                        end
                        PH_FIXED: begin
                            cur_skip = cur_skip - 1'b1;
                            if (cur_skip == '0) begin
                                cur_phase = section_after(LVL_FIXED);
                            end
                        end
                        PH_XLEN_LO: begin
                            cur_skip  = {8'h00, d};
                            cur_phase = PH_XLEN_HI;
                        end
                        PH_XLEN_HI: begin
                            cur_skip = {d, cur_skip[7:0]};
                            if (cur_skip == '0) begin
                                cur_phase = section_after(LVL_EXTRA);
                            end else begin
                                cur_phase = PH_EXTRA;
                            end
                        end
                        PH_EXTRA: begin
                            cur_skip = cur_skip - 1'b1;
                            if (cur_skip == '0) begin
                                cur_phase = section_after(LVL_EXTRA);
                            end
                        end
                        PH_NAME: begin
                            if (d == 8'h00) begin
                                cur_phase = section_after(LVL_NAME);
                            end
                        end
                        PH_COMMENT: begin
                            if (d == 8'h00) begin
                                cur_phase = section_after(LVL_COMMENT);
                            end
                        end
                        default: begin
                            cur_skip = cur_skip - 1'b1;
                            if (cur_skip == '0) begin
                                cur_phase = PH_PAYLOAD;
                            end
                        end
                    endcase

                    // Resolve the label from the phase just entered.
                    if (cur_phase == PH_RAW) begin
                        cur_offset      = '0;
                        lab.byte_status = ST_RAW;
                        if (it.last_byte) begin
                            restart_parse();
                        end
                    end else if (cur_phase == PH_BAD) begin
                        lab.byte_status = ST_BAD;
                    end else if (it.last_byte) begin
                        cur_phase       = PH_NODATA;
                        lab.byte_status = ST_NODATA;
                    end
                end
            end
        endcase
        return lab;
    endfunction

    // Send one request and record its predicted label once accepted.
    task automatic send_byte(input in_item_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_labels.push_back(predict_label(it));
        sent_count++;
    endtask

    // Hold the sender until every predicted label has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_labels.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        in_item_t it;
        it.data_byte  = b;
        it.first_byte = 1'b0;
        it.last_byte  = 1'b0;
        image_bytes.push_back(it);
    endtask

    task automatic add_random_bytes(input int count);
        repeat (count) begin
            add_byte(8'($urandom_range(255)));
        end
    endtask

    // Mark the ends of the assembled image and send it.
    task automatic send_image(input logic mark_first, input logic mark_last);
        image_bytes[0].first_byte = mark_first;
        image_bytes[image_bytes.size() - 1].last_byte = mark_last;
        foreach (image_bytes[i]) begin
            send_byte(image_bytes[i]);
        end
        image_bytes.delete();
    endtask

    // Append a well-formed gzip header with random section contents.
    task automatic add_gzip_header(input logic [7:0] flg);
        int xlen;
        xlen = ($urandom_range(9) == 0) ? $urandom_range(263, 256) : $urandom_range(6);
        add_byte(MAGIC1_BYTE);
        add_byte(MAGIC2_BYTE);
        add_byte(METHOD_DEFL);
        add_byte(flg);
        add_random_bytes(6);
        if (flg[2]) begin
            add_byte(xlen[7:0]);
            add_byte(xlen[15:8]);
            add_random_bytes(xlen);
        end
        if (flg[3]) begin
            repeat ($urandom_range(5)) add_byte(8'($urandom_range(255, 1)));
            add_byte(8'h00);
        end
        if (flg[4]) begin
            repeat ($urandom_range(5)) add_byte(8'($urandom_range(255, 1)));
            add_byte(8'h00);
        end
        if (flg[1]) begin
            add_random_bytes(2);
        end
    endtask

    // One random image: mostly well-formed, the rest cut short, broken, raw or noise.
    task automatic send_random_image();
        int kind;
        int n;
        logic [7:0] flg;
        logic [7:0] b;
        logic mark_first;
        in_item_t it;
        kind = $urandom_range(99);
        mark_first = restart_next || ($urandom_range(9) != 0);
        restart_next = 1'b0;
        flg = 8'($urandom_range(31));
        if (kind >= 92) begin
            // Noise with random marks; the next image restarts explicitly.
            repeat (12) begin
                it.data_byte  = 8'($urandom_range(255));
                it.first_byte = ($urandom_range(5) == 0);
                it.last_byte  = ($urandom_range(5) == 0);
                send_byte(it);
            end
            restart_next = 1'b1;
        end else if (kind >= 78 && kind < 86) begin
            // Raw image: a wrong first or second magic byte.
            b = 8'($urandom_range(255));
            if ($urandom_range(1) == 0) begin
                add_byte((b == MAGIC1_BYTE) ? 8'h00 : b);
            end else begin
                add_byte(MAGIC1_BYTE);
                add_byte((b == MAGIC2_BYTE) ? 8'h00 : b);
            end
            add_random_bytes($urandom_range(6));
            send_image(mark_first, 1'b1);
        end else begin
            add_gzip_header(flg);
            if (kind < 60) begin
                add_random_bytes($urandom_range(8, 1));
                send_image(mark_first, 1'b1);
            end else if (kind < 70) begin
                // Image cut within its header, then up to three random bytes.
                n = $urandom_range(image_bytes.size(), 1);
                image_bytes = image_bytes[0:n-1];
                add_random_bytes($urandom_range(1) * $urandom_range(3));
                send_image(mark_first, 1'b1);
            end else if (kind < 78) begin
                // Bad method or a reserved flag bit set.
                if (kind[0]) begin
                    b = 8'($urandom_range(255));
                    image_bytes[2].data_byte = (b == METHOD_DEFL) ? 8'h09 : b;
                end else begin
                    image_bytes[3].data_byte = flg | (8'($urandom_range(7, 1)) << 5);
                end
                add_random_bytes($urandom_range(3));
                send_image(mark_first, 1'b1);
            end else begin
                // Stream cut off without a last mark; the next image restarts.
                n = $urandom_range(image_bytes.size() + 3, 1);
                if (n > image_bytes.size()) begin
                    add_random_bytes(n - image_bytes.size());
                end else begin
                    image_bytes = image_bytes[0:n-1];
                end
                send_image(mark_first, 1'b0);
                restart_next = 1'b1;
            end
        end
    endtask

    // Raw images: wrong magic, a lone byte, and an image with no first mark.
    task automatic test_raw_images();
        add_byte(8'h00);
        send_image(1'b1, 1'b1);
        add_byte(MAGIC1_BYTE);
        send_image(1'b1, 1'b1);
        add_byte(MAGIC1_BYTE);
        add_byte(8'h00);
        add_byte(8'hff);
        send_image(1'b1, 1'b1);
        add_byte(8'h55);
        add_byte(8'haa);
        send_image(1'b0, 1'b1);
    endtask

    // Bad method and a reserved flag bit, both sticky to the end of the image.
    task automatic test_bad_format();
        add_byte(MAGIC1_BYTE);
        add_byte(MAGIC2_BYTE);
        add_byte(8'h07);
        add_byte(8'hff);
        send_image(1'b1, 1'b1);
        add_byte(MAGIC1_BYTE);
        add_byte(MAGIC2_BYTE);
        add_byte(METHOD_DEFL);
        add_byte(8'h80);
        add_byte(8'h00);
        send_image(1'b1, 1'b1);
    endtask

    // Every optional section present, then two payload bytes.
    task automatic test_full_header();
        add_byte(MAGIC1_BYTE);
        add_byte(MAGIC2_BYTE);
        add_byte(METHOD_DEFL);
        add_byte(8'h1f);
        add_random_bytes(6);
        add_byte(8'h01);
        add_byte(8'h00);
        add_byte(8'hff);
        add_byte(8'h41);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h12);
        add_byte(8'h34);
        add_byte(8'h00);
        add_byte(8'hff);
        send_image(1'b1, 1'b1);
    endtask

    // Last mark inside the header, then a byte with no first mark stays out of data.
    task automatic test_out_of_data();
        add_byte(MAGIC1_BYTE);
        add_byte(MAGIC2_BYTE);
        send_image(1'b1, 1'b1);
        add_byte(8'h3c);
        send_image(1'b0, 1'b0);
    endtask

    // Random images; an early stretch runs without idling, and the sender drains once.
    task automatic test_random_images();
        int start_count;
        bit drained;
        start_count = sent_count;
        drained = 1'b0;
        idle_pct = 0;
        restart_next = 1'b1;
        while (sent_count - start_count < RANDOM_BYTES) begin
            if (sent_count - start_count > 300) begin
                idle_pct = 17;
            end
            if (!drained && sent_count - start_count > 700) begin
                wait_for_results();
                drained = 1'b1;
            end
            send_random_image();
        end
    endtask

    // Compare each returned label with the oldest prediction.
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_labels.size() == 0) begin
                report_mismatch("label returned with no request outstanding");
            end else begin
                want = expected_labels.pop_front();
                if (m_data.byte_status !== want.byte_status) begin
                    report_mismatch($sformatf("byte_status %0d, expected %0d",
                        m_data.byte_status, want.byte_status));
                end
                if (m_data.header_length !== want.header_length) begin
                    report_mismatch($sformatf("header_length %0d, expected %0d",
                        m_data.header_length, want.header_length));
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("gzip_header_skipper_tb: errors");
        $finish;
    end

    initial begin
        restart_parse();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_raw_images();
        test_bad_format();
        test_full_header();
        test_out_of_data();
        test_random_images();

        // Let the last labels drain before the verdict.
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && expected_labels.size() == 0) begin
            $display("gzip_header_skipper_tb: clean");
        end else begin
            $display("gzip_header_skipper_tb: errors");
        end
        $finish;
    end

endmodule

// ===== gzip_header_skipper.f =====
+incdir+rtl
rtl/ghs_pkg.sv
rtl/ghs_in_stage.sv
rtl/ghs_parser.sv
rtl/ghs_out_stage.sv
rtl/gzip_header_skipper.sv
dv/gzip_header_skipper_tb.sv
